// ----- design/lea_pkg.sv -----
// Shared types, opcode constants and helpers for the LEA effective-address unit.
// No dependencies; used by every module in design/.
package lea_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_LEA    = 3'd0,
        ST_NOOP   = 3'd1,
        ST_UNHAND = 3'd2,
        ST_MOVEM  = 3'd3,
        ST_BADMOD = 3'd4
    } status_t;

    // Front decoder state: what the next stream word is
    typedef enum logic [1:0] {
        FS_OPCODE   = 2'd0,
        FS_EXT_HIGH = 2'd1,
        FS_EXT_LAST = 2'd2
    } front_state_t;

    // Command handed from the front to the back through the queue
    typedef struct packed {
        status_t     status;
        logic        use_reg;   // add An[src] to operand
        logic [2:0]  src;
        logic [2:0]  dest;
        logic [31:0] operand;
    } cmd_t;

    // Opcode patterns
    localparam logic [15:0] LEA_MASK    = 16'hF1C0;
    localparam logic [15:0] LEA_MATCH   = 16'h41C0;
    localparam logic [15:0] MOVEM_MASK  = 16'hFB80;
    localparam logic [15:0] MOVEM_MATCH = 16'h4880;
    localparam logic [15:0] OP_RESET    = 16'h4E70;
    localparam logic [15:0] OP_NOP      = 16'h4E71;
    localparam logic [15:0] OP_STOP     = 16'h4E72;
    localparam logic [15:0] OP_RTE      = 16'h4E73;
    localparam logic [15:0] OP_TRAPV    = 16'h4E76;
    localparam logic [15:0] OP_RTR      = 16'h4E77;

    // Addressing mode field values
    localparam logic [2:0] MODE_IND     = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_EXT     = 3'd7;
    localparam logic [2:0] REG_ABS_W    = 3'd0;
    localparam logic [2:0] REG_ABS_L    = 3'd1;
    localparam logic [2:0] REG_PC_DISP  = 3'd2;
    localparam logic [2:0] REG_FIRST_UNHAND = 3'd5;

    function automatic logic [31:0] sext16(input logic [15:0] w);
        sext16 = {{16{w[15]}}, w};
    endfunction

endpackage

// ----- design/lea_front.sv -----
// Front end: takes stream words, tracks the program counter and extension words,
// and classifies each opcode into a command. Depends on lea_pkg.
module lea_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [31:0]       cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              queue_full,
    output logic              push,
    output lea_pkg::cmd_t     push_cmd
);

    lea_pkg::front_state_t state_reg, state_next;
    logic [31:0] pc_reg, pc_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] hold_reg, hold_next;
    logic [31:0] ext_addr_reg, ext_addr_next;

    logic        accept;
    logic [31:0] pc_inc;
    logic [2:0]  w_mode, w_reg, p_mode, p_reg;
    logic        emit;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign pc_inc   = pc_reg + 32'd2;
    assign w_mode   = s_tdata[5:3];
    assign w_reg    = s_tdata[2:0];
    assign p_mode   = pending_reg[5:3];
    assign p_reg    = pending_reg[2:0];
    assign push     = accept && emit;

    // State and context registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lea_pkg::FS_OPCODE;
            pc_reg       <= 32'd0;
            pending_reg  <= 16'd0;
            hold_reg     <= 16'd0;
            ext_addr_reg <= 32'd0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            pending_reg  <= pending_next;
            hold_reg     <= hold_next;
            ext_addr_reg <= ext_addr_next;
        end
    end

    // Decode and next state
    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        pending_next  = pending_reg;
        hold_next     = hold_reg;
        ext_addr_next = ext_addr_reg;
        emit          = 1'b0;
        push_cmd      = '{status: lea_pkg::ST_UNHAND, use_reg: 1'b0, src: 3'd0,
                          dest: 3'd0, operand: 32'd0};

        if (cfg_valid) begin
            pc_next = cfg_data;
        end

        if (accept) begin
            pc_next = pc_inc;
            case (state_reg)
                lea_pkg::FS_OPCODE: begin
                    emit = 1'b1;
                    if ((s_tdata & lea_pkg::LEA_MASK) == lea_pkg::LEA_MATCH) begin
                        pending_next = s_tdata;
                        case (w_mode)
                            lea_pkg::MODE_IND, lea_pkg::MODE_POSTINC,
                            lea_pkg::MODE_PREDEC: begin
                                push_cmd.status  = lea_pkg::ST_LEA;
                                push_cmd.use_reg = 1'b1;
                                push_cmd.src     = w_reg;
                                push_cmd.dest    = s_tdata[11:9];
                            end
                            lea_pkg::MODE_DISP: begin
                                emit          = 1'b0;
                                state_next    = lea_pkg::FS_EXT_LAST;
                                ext_addr_next = pc_inc;
                            end
                            lea_pkg::MODE_EXT: begin
                                if (w_reg == lea_pkg::REG_ABS_W ||
                                    w_reg == lea_pkg::REG_PC_DISP) begin
                                    emit          = 1'b0;
                                    state_next    = lea_pkg::FS_EXT_LAST;
                                    ext_addr_next = pc_inc;
                                end else if (w_reg == lea_pkg::REG_ABS_L) begin
                                    emit          = 1'b0;
                                    state_next    = lea_pkg::FS_EXT_HIGH;
                                    ext_addr_next = pc_inc;
                                end else if (w_reg >= lea_pkg::REG_FIRST_UNHAND) begin
                                    push_cmd.status = lea_pkg::ST_UNHAND;
                                end else begin
                                    push_cmd.status = lea_pkg::ST_BADMOD;
                                end
                            end
                            default: begin
                                push_cmd.status = lea_pkg::ST_BADMOD;
                            end
                        endcase
                    end else if ((s_tdata & lea_pkg::MOVEM_MASK) == lea_pkg::MOVEM_MATCH) begin
                        if (w_mode == lea_pkg::MODE_EXT &&
                            w_reg >= lea_pkg::REG_FIRST_UNHAND) begin
                            push_cmd.status = lea_pkg::ST_UNHAND;
                        end else begin
                            push_cmd.status = lea_pkg::ST_MOVEM;
                        end
                    end else if (s_tdata == lea_pkg::OP_RESET || s_tdata == lea_pkg::OP_NOP ||
                                 s_tdata == lea_pkg::OP_STOP  || s_tdata == lea_pkg::OP_RTE ||
                                 s_tdata == lea_pkg::OP_TRAPV || s_tdata == lea_pkg::OP_RTR) begin
                        push_cmd.status = lea_pkg::ST_NOOP;
                    end else begin
                        push_cmd.status = lea_pkg::ST_UNHAND;
                    end
                end
                lea_pkg::FS_EXT_HIGH: begin
                    hold_next  = s_tdata;
                    state_next = lea_pkg::FS_EXT_LAST;
                end
                lea_pkg::FS_EXT_LAST: begin
                    emit            = 1'b1;
                    state_next      = lea_pkg::FS_OPCODE;
                    push_cmd.status = lea_pkg::ST_LEA;
                    push_cmd.dest   = pending_reg[11:9];
                    if (p_mode == lea_pkg::MODE_DISP) begin
                        push_cmd.use_reg = 1'b1;
                        push_cmd.src     = p_reg;
                        push_cmd.operand = lea_pkg::sext16(s_tdata);
                    end else if (p_reg == lea_pkg::REG_ABS_W) begin
                        push_cmd.operand = lea_pkg::sext16(s_tdata);
                    end else if (p_reg == lea_pkg::REG_ABS_L) begin
                        push_cmd.operand = {hold_reg, s_tdata};
                    end else begin
                        push_cmd.operand = ext_addr_reg + lea_pkg::sext16(s_tdata);
                    end
                end
                default: begin
                    state_next = lea_pkg::FS_OPCODE;
                end
            endcase
        end
    end

    // Extension states are only entered from an LEA opcode
    a_ext_pending_lea: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != lea_pkg::FS_OPCODE |->
            (pending_reg & lea_pkg::LEA_MASK) == lea_pkg::LEA_MATCH)
        else $error("extension state without a pending LEA");

    // High-word state only for absolute long
    a_high_abs_long: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lea_pkg::FS_EXT_HIGH |->
            p_mode == lea_pkg::MODE_EXT && p_reg == lea_pkg::REG_ABS_L)
        else $error("high-word state for a mode other than absolute long");

    // A request is queued only when the queue has room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !queue_full)
        else $error("push into a full queue");

endmodule

// ----- design/lea_cmd_fifo.sv -----
// Short command queue between the front decoder and the back end.
// Depends on lea_pkg for the command type.
module lea_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lea_pkg::cmd_t push_cmd,
    input  logic          pop,
    output lea_pkg::cmd_t head_cmd,
    output logic          empty,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lea_pkg::cmd_t    store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign head_cmd = store_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

// ----- design/lea_back.sv -----
// Back end: holds the address registers, forms the effective address,
// writes An and drives the registered result. Depends on lea_pkg.
module lea_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  lea_pkg::cmd_t     head_cmd,
    input  logic              queue_empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic [2:0]        m_tuser
);

    logic [31:0]      an_reg [8];
    logic [31:0]      ea;
    logic             m_valid_reg;
    lea_pkg::status_t m_status_reg;
    logic [2:0]       m_dst_reg;
    logic [31:0]      m_value_reg;

    // Take a command whenever the output register is free or being drained
    assign pop = !queue_empty && (!m_valid_reg || m_tready);
    assign ea  = head_cmd.use_reg ? (an_reg[head_cmd.src] + head_cmd.operand)
                                  : head_cmd.operand;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_value_reg, m_dst_reg};

    // Address register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                an_reg[i] <= 32'd0;
            end
        end else if (pop && head_cmd.status == lea_pkg::ST_LEA) begin
            an_reg[head_cmd.dest] <= ea;
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_status_reg <= head_cmd.status;
            m_dst_reg    <= head_cmd.dest;
            m_value_reg  <= ea;
        end
    end

    a_nonlea_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != lea_pkg::ST_LEA |->
            m_dst_reg == 3'd0 && m_value_reg == 32'd0)
        else $error("non-LEA result with nonzero register or address");

    a_lea_written: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head_cmd.status == lea_pkg::ST_LEA |=> an_reg[m_dst_reg] == m_value_reg)
        else $error("LEA result does not match the written register");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg)
        else $error("command taken but no result shown");

endmodule

// ----- design/lea_effective_address_unit.sv -----
// LEA effective-address unit: one 16-bit instruction word accepted per cycle,
// sustained, while the result side keeps up. A result is queued, then registered,
// after the word completing it (opcode or last extension) is accepted; the command
// queue plus the output register absorb result-side stalls. Reset (aresetn low,
// synchronous) clears An0-An7, the PC (to 0), decoder state and the queue.
// Depends on lea_pkg, lea_front, lea_cmd_fifo, lea_back.
module lea_effective_address_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // start_pc write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // instruction words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] instruction_word
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [2:0] dest_an, [34:3] address_value, rest zero
    output logic [2:0]  m_tuser     // [2:0] status
);

    logic          push, pop, q_empty, q_full;
    lea_pkg::cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    lea_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    lea_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    lea_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .queue_empty (q_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
